FILE: design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// shared types, constants and small tables of the tilt compensated compass
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int XyW  = 40;   // cordic x/y datapath
   localparam int ZW   = 34;   // angle datapath, q28 radians
   localparam int MulW = 34;   // shared multiplier operand width

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] scaled_x;
      logic signed [15:0] scaled_y;
      logic signed [15:0] scaled_z;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] heading_angle;
   } rsp_data_type;

   typedef struct packed {
      logic start;
      logic rotate;
   } cord_ctl_type;

   localparam logic signed [ZW-1:0]  PI_Q28      = 34'sd843314857;
   localparam logic signed [ZW-1:0]  HALF_PI_Q28 = 34'sd421657428;
   localparam logic signed [ZW-1:0]  TWO_PI_Q28  = 34'sd1686629713;
   localparam logic signed [XyW-1:0] K_Q30       = 40'sd652032874;

   localparam logic [2:0] REG_ACC_SCALE    = 3'd0;
   localparam logic [2:0] REG_MAG_SCALE    = 3'd1;
   localparam logic [2:0] REG_MAG_OFFSET_X = 3'd2;
   localparam logic [2:0] REG_MAG_OFFSET_Y = 3'd3;
   localparam logic [2:0] REG_MAG_OFFSET_Z = 3'd4;
   localparam logic [2:0] REG_ACC_COEF     = 3'd5;
   localparam logic [2:0] REG_MAG_COEF     = 3'd6;

   localparam logic [16:0] COEF_ONE = 17'd65536;

   // arctangent of 2^-i in q28
   function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] idx);
      logic signed [ZW-1:0] res;
      unique case (idx)
         5'd0: res = 34'sd210828714;
         5'd1: res = 34'sd124459457;
         5'd2: res = 34'sd65760959;
         5'd3: res = 34'sd33381290;
         5'd4: res = 34'sd16755422;
         5'd5: res = 34'sd8385879;
         5'd6: res = 34'sd4193963;
         5'd7: res = 34'sd2097109;
         5'd8: res = 34'sd1048571;
         5'd9: res = 34'sd524287;
         default: res = $signed(ZW'(1) << (5'd28 - idx));
      endcase
      return res;
   endfunction

   // full scale in mg per 2^15 counts
   function automatic logic [14:0] acc_fs(input logic [1:0] code);
      logic [14:0] res;
      unique case (code)
         2'd0: res = 15'd4000;
         2'd1: res = 15'd8000;
         2'd2: res = 15'd16000;
         default: res = 15'd32000;
      endcase
      return res;
   endfunction

   // full scale in mgauss per 2^15 counts, codes 6 and 7 as the widest range
   function automatic logic [14:0] mag_fs(input logic [2:0] code);
      logic [14:0] res;
      unique case (code)
         3'd0: res = 15'd2600;
         3'd1: res = 15'd3800;
         3'd2: res = 15'd5000;
         3'd3: res = 15'd8000;
         3'd4: res = 15'd9400;
         3'd5: res = 15'd11200;
         default: res = 15'd16200;
      endcase
      return res;
   endfunction

   // q28 radians to q3.12, round half up, saturate
   function automatic logic signed [15:0] to_q12(input logic signed [ZW-1:0] z);
      logic signed [ZW:0] v;
      logic signed [15:0] res;
      v = ($signed({z[ZW-1], z}) + 35'sd32768) >>> 16;
      if (v > 35'sd32767) res = 16'sh7fff;
      else if (v < -35'sd32768) res = 16'sh8000;
      else res = v[15:0];
      return res;
   endfunction

endpackage

FILE: design/tilt_compensated_compass.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass
// tilt compensated e-compass with exponentially averaged sensor vectors
// ----------------------------------------------------------------------------
// One request transfer carries a raw three-axis sample, tagged accelerometer
// or magnetometer. Magnetometer counts get the programmed offsets (16-bit
// wrap), the sample is scaled to mg or mgauss, returned as scaled_x/y/z and
// folded into that sensor's Q16.16 exponential moving average. Roll, pitch
// and heading are then worked out from both filtered vectors and returned in
// Q3.12 radians in the same response transfer. All arithmetic runs on one
// 34x34 multiplier, a bit-pair square root and one iterative cordic unit
// under a small sequencer, so one item is in flight at a time: pitch is
// wrapped into -pi..pi before its sin/cos pass when needed, and the next
// request can be taken in the cycle after the response is loaded. The work
// is the 32-step square root, the five cordic passes (pitch, roll, sin/cos
// of roll, sin/cos of pitch, heading), the SMUL, SRND, FMUL and FUPD states
// per axis for scaling and filtering, and seven multiply steps for the
// heading terms. The finished response sits in an output register, so the
// next request is taken while it waits. Filters clear to zero on reset, so
// pitch reads -pi until the accelerometer has been sampled. Registers sit at
// byte address 4*i: acc_scale, mag_scale, mag_offset_x/y/z, acc_coef,
// mag_coef; coefficients whose low 17 bits exceed 65536 saturate to 65536.
// ----------------------------------------------------------------------------
module tilt_compensated_compass import tcc_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_SMUL   = 14'b00000000000010,
      ST_SRND   = 14'b00000000000100,
      ST_FMUL   = 14'b00000000001000,
      ST_FUPD   = 14'b00000000010000,
      ST_SQA    = 14'b00000000100000,
      ST_SQB    = 14'b00000001000000,
      ST_SQC    = 14'b00000010000000,
      ST_SQRT   = 14'b00000100000000,
      ST_LAUNCH = 14'b00001000000000,
      ST_CWAIT  = 14'b00010000000000,
      ST_PMUL   = 14'b00100000000000,
      ST_PACC   = 14'b01000000000000,
      ST_DONE   = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      JOB_PITCH,
      JOB_ROLL,
      JOB_SROLL,
      JOB_SPITCH,
      JOB_HEAD
   } job_type;

   // configuration
   logic [1:0]         acc_scale_ff, acc_scale_in;
   logic [2:0]         mag_scale_ff, mag_scale_in;
   logic signed [15:0] off_x_ff, off_x_in, off_y_ff, off_y_in, off_z_ff, off_z_in;
   logic [16:0]        acc_coef_ff, acc_coef_in, mag_coef_ff, mag_coef_in;

   // sequencer and datapath
   state_type           state_ff, state_in;
   job_type             job_ff, job_in;
   logic [1:0]          k_ff, k_in;
   logic [2:0]          mstep_ff, mstep_in;
   logic                type_ff, type_in;
   logic signed [15:0]  v_ff [3];
   logic signed [15:0]  v_in [3];
   logic signed [15:0]  s_ff [3];
   logic signed [15:0]  s_in [3];
   logic signed [31:0]  acc_f_ff [3];
   logic signed [31:0]  acc_f_in [3];
   logic signed [31:0]  mag_f_ff [3];
   logic signed [31:0]  mag_f_in [3];
   logic signed [2*MulW-1:0] product_ff, product_in;
   logic [63:0]         sq_a_ff, sq_a_in, sq_n_ff, sq_n_in, sq_r_ff, sq_r_in, sq_b_ff, sq_b_in;
   logic [4:0]          sq_cnt_ff, sq_cnt_in;
   logic signed [ZW-1:0] pitch_ff, pitch_in, roll_ff, roll_in, head_ff, head_in;
   logic signed [ZW-1:0] zwrap_ff, zwrap_in;
   logic signed [MulW-1:0] cr_ff, cr_in, sr_ff, sr_in, cp_ff, cp_in, sp_ff, sp_in;
   logic signed [MulW-1:0] srsp_ff, srsp_in, crsp_ff, crsp_in;
   logic signed [XyW-1:0]  mxi_ff, mxi_in, myi_ff, myi_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_data_type        rsp_data_ff, rsp_data_in;

   // shared units
   logic signed [MulW-1:0] mul_a, mul_b;
   cord_ctl_type           cord_ctl;
   logic signed [XyW-1:0]  cx_start, cy_start, cx_res, cy_res;
   logic signed [ZW-1:0]   cz_res;
   logic                   cord_done;

   logic                   csr_wr;
   logic [16:0]            coef_wr;
   logic                   req_take;
   logic signed [15:0]     v_cur, s_cur;
   logic signed [31:0]     f_cur, f_new;
   logic [14:0]            fs_cur;
   logic [16:0]            coef_cur;
   logic signed [32:0]     fold_d;
   logic signed [2*MulW-1:0] round_sum;
   logic signed [XyW-1:0]  prod_t;
   logic [63:0]            sq_rb;
   logic                   need_wrap;

   tcc_cordic #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .cord_ctl (cord_ctl),
      .x_start  (cx_start),
      .y_start  (cy_start),
      .z_start  (zwrap_ff),
      .done     (cord_done),
      .x_res    (cx_res),
      .y_res    (cy_res),
      .z_res    (cz_res)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid & req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign coef_wr    = (csr_pwdata[16:0] > COEF_ONE) ? COEF_ONE : csr_pwdata[16:0];

   // register read
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ACC_SCALE:    csr_prdata = {30'd0, acc_scale_ff};
         REG_MAG_SCALE:    csr_prdata = {29'd0, mag_scale_ff};
         REG_MAG_OFFSET_X: csr_prdata = 32'(off_x_ff);
         REG_MAG_OFFSET_Y: csr_prdata = 32'(off_y_ff);
         REG_MAG_OFFSET_Z: csr_prdata = 32'(off_z_ff);
         REG_ACC_COEF:     csr_prdata = {15'd0, acc_coef_ff};
         REG_MAG_COEF:     csr_prdata = {15'd0, mag_coef_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // per-axis operands
   always_comb begin
      v_cur     = v_ff[k_ff];
      s_cur     = s_ff[k_ff];
      f_cur     = type_ff ? mag_f_ff[k_ff] : acc_f_ff[k_ff];
      fs_cur    = type_ff ? mag_fs(mag_scale_ff) : acc_fs(acc_scale_ff);
      coef_cur  = type_ff ? mag_coef_ff : acc_coef_ff;
      fold_d    = 33'($signed({s_cur, 16'h0000})) - 33'(f_cur);
      round_sum = product_ff + (2*MulW)'(16384);
      f_new     = f_cur + product_ff[47:16];
      prod_t    = XyW'(product_ff >>> 30);
      sq_rb     = sq_r_ff + sq_b_ff;
      need_wrap = ((job_ff == JOB_SROLL) || (job_ff == JOB_SPITCH)) &&
                  ((zwrap_ff > PI_Q28) || (zwrap_ff < -PI_Q28));
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SMUL: begin
            mul_a = MulW'(v_cur);
            mul_b = $signed({19'd0, fs_cur});
         end
         ST_FMUL: begin
            mul_a = $signed({17'd0, coef_cur});
            mul_b = MulW'(fold_d);
         end
         ST_SQA: begin
            mul_a = MulW'(acc_f_ff[1]);
            mul_b = MulW'(acc_f_ff[1]);
         end
         ST_SQB: begin
            mul_a = MulW'(acc_f_ff[2]);
            mul_b = MulW'(acc_f_ff[2]);
         end
         ST_PMUL: begin
            unique case (mstep_ff)
               3'd0: begin mul_a = sr_ff;   mul_b = sp_ff; end
               3'd1: begin mul_a = cr_ff;   mul_b = sp_ff; end
               3'd2: begin mul_a = cp_ff;   mul_b = MulW'(mag_f_ff[0]); end
               3'd3: begin mul_a = srsp_ff; mul_b = MulW'(mag_f_ff[1]); end
               3'd4: begin mul_a = crsp_ff; mul_b = MulW'(mag_f_ff[2]); end
               3'd5: begin mul_a = cr_ff;   mul_b = MulW'(mag_f_ff[1]); end
               default: begin mul_a = sr_ff; mul_b = MulW'(mag_f_ff[2]); end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product_in = mul_a * mul_b;
   end

   // cordic start operands per job
   always_comb begin
      cord_ctl.start  = (state_ff == ST_LAUNCH) && !need_wrap;
      cord_ctl.rotate = (job_ff == JOB_SROLL) || (job_ff == JOB_SPITCH);
      unique case (job_ff)
         JOB_PITCH: begin
            cx_start = XyW'(acc_f_ff[2]);
            cy_start = XyW'(acc_f_ff[1]);
         end
         JOB_ROLL: begin
            cx_start = $signed({8'd0, sq_r_ff[31:0]});
            cy_start = -XyW'(acc_f_ff[0]);
         end
         JOB_HEAD: begin
            cx_start = mxi_ff;
            cy_start = myi_ff;
         end
         default: begin
            cx_start = '0;
            cy_start = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      acc_scale_in = acc_scale_ff;
      mag_scale_in = mag_scale_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      off_z_in     = off_z_ff;
      acc_coef_in  = acc_coef_ff;
      mag_coef_in  = mag_coef_ff;
      state_in     = state_ff;
      job_in       = job_ff;
      k_in         = k_ff;
      mstep_in     = mstep_ff;
      type_in      = type_ff;
      v_in         = v_ff;
      s_in         = s_ff;
      acc_f_in     = acc_f_ff;
      mag_f_in     = mag_f_ff;
      sq_a_in      = sq_a_ff;
      sq_n_in      = sq_n_ff;
      sq_r_in      = sq_r_ff;
      sq_b_in      = sq_b_ff;
      sq_cnt_in    = sq_cnt_ff;
      pitch_in     = pitch_ff;
      roll_in      = roll_ff;
      head_in      = head_ff;
      zwrap_in     = zwrap_ff;
      cr_in        = cr_ff;
      sr_in        = sr_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      srsp_in      = srsp_ff;
      crsp_in      = crsp_ff;
      mxi_in       = mxi_ff;
      myi_in       = myi_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_ACC_SCALE:    acc_scale_in = csr_pwdata[1:0];
            REG_MAG_SCALE:    mag_scale_in = csr_pwdata[2:0];
            REG_MAG_OFFSET_X: off_x_in     = csr_pwdata[15:0];
            REG_MAG_OFFSET_Y: off_y_in     = csr_pwdata[15:0];
            REG_MAG_OFFSET_Z: off_z_in     = csr_pwdata[15:0];
            REG_ACC_COEF:     acc_coef_in  = coef_wr;
            REG_MAG_COEF:     mag_coef_in  = coef_wr;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               type_in = req_data.req_type;
               // magnetometer offsets wrap at 16 bits
               if (req_data.req_type) begin
                  v_in[0] = req_data.raw_x + off_x_ff;
                  v_in[1] = req_data.raw_y + off_y_ff;
                  v_in[2] = req_data.raw_z + off_z_ff;
               end else begin
                  v_in[0] = req_data.raw_x;
                  v_in[1] = req_data.raw_y;
                  v_in[2] = req_data.raw_z;
               end
               k_in     = 2'd0;
               state_in = ST_SMUL;
            end
         end
         ST_SMUL: state_in = ST_SRND;
         ST_SRND: begin
            s_in[k_ff] = round_sum[30:15];
            state_in   = ST_FMUL;
         end
         ST_FMUL: state_in = ST_FUPD;
         ST_FUPD: begin
            if (type_ff) mag_f_in[k_ff] = f_new;
            else acc_f_in[k_ff] = f_new;
            if (k_ff == 2'd2) begin
               state_in = ST_SQA;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SMUL;
            end
         end
         ST_SQA: state_in = ST_SQB;
         ST_SQB: begin
            sq_a_in  = product_ff[63:0];
            state_in = ST_SQC;
         end
         ST_SQC: begin
            sq_n_in   = sq_a_ff + product_ff[63:0];
            sq_r_in   = '0;
            sq_b_in   = 64'h4000_0000_0000_0000;
            sq_cnt_in = '0;
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            // one result bit per step
            if (sq_n_ff >= sq_rb) begin
               sq_n_in = sq_n_ff - sq_rb;
               sq_r_in = (sq_r_ff >> 1) + sq_b_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_b_in   = sq_b_ff >> 2;
            sq_cnt_in = sq_cnt_ff + 5'd1;
            if (sq_cnt_ff == 5'd31) begin
               job_in   = JOB_PITCH;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            // bring a rotation angle into -pi..pi first
            priority if (need_wrap && (zwrap_ff > PI_Q28)) zwrap_in = zwrap_ff - TWO_PI_Q28;
            else if (need_wrap) zwrap_in = zwrap_ff + TWO_PI_Q28;
            else state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (cord_done) begin
               unique case (job_ff)
                  JOB_PITCH: begin
                     pitch_in = cz_res - PI_Q28;
                     job_in   = JOB_ROLL;
                     state_in = ST_LAUNCH;
                  end
                  JOB_ROLL: begin
                     roll_in  = cz_res;
                     zwrap_in = cz_res;
                     job_in   = JOB_SROLL;
                     state_in = ST_LAUNCH;
                  end
                  JOB_SROLL: begin
                     cr_in    = MulW'(cx_res);
                     sr_in    = MulW'(cy_res);
                     zwrap_in = pitch_ff;
                     job_in   = JOB_SPITCH;
                     state_in = ST_LAUNCH;
                  end
                  JOB_SPITCH: begin
                     cp_in    = MulW'(cx_res);
                     sp_in    = MulW'(cy_res);
                     mstep_in = 3'd0;
                     state_in = ST_PMUL;
                  end
                  default: begin
                     head_in  = cz_res;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PMUL: state_in = ST_PACC;
         ST_PACC: begin
            // mxi = cp mx + srsp my + crsp mz, myi = cr my - sr mz
            unique case (mstep_ff)
               3'd0: srsp_in = MulW'(prod_t);
               3'd1: crsp_in = MulW'(prod_t);
               3'd2: mxi_in  = prod_t;
               3'd3: mxi_in  = mxi_ff + prod_t;
               3'd4: mxi_in  = mxi_ff + prod_t;
               3'd5: myi_in  = prod_t;
               default: myi_in = myi_ff - prod_t;
            endcase
            if (mstep_ff == 3'd6) begin
               job_in   = JOB_HEAD;
               state_in = ST_LAUNCH;
            end else begin
               mstep_in = mstep_ff + 3'd1;
               state_in = ST_PMUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.scaled_x      = s_ff[0];
               rsp_data_in.scaled_y      = s_ff[1];
               rsp_data_in.scaled_z      = s_ff[2];
               rsp_data_in.roll_angle    = to_q12(roll_ff);
               rsp_data_in.pitch_angle   = to_q12(pitch_ff);
               rsp_data_in.heading_angle = to_q12(head_ff);
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_scale_ff <= '0;
         mag_scale_ff <= '0;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
         off_z_ff     <= '0;
         acc_coef_ff  <= COEF_ONE;
         mag_coef_ff  <= COEF_ONE;
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_PITCH;
         rsp_valid_ff <= 1'b0;
         acc_f_ff     <= '{default: '0};
         mag_f_ff     <= '{default: '0};
      end else begin
         acc_scale_ff <= acc_scale_in;
         mag_scale_ff <= mag_scale_in;
         off_x_ff     <= off_x_in;
         off_y_ff     <= off_y_in;
         off_z_ff     <= off_z_in;
         acc_coef_ff  <= acc_coef_in;
         mag_coef_ff  <= mag_coef_in;
         state_ff     <= state_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_f_ff     <= acc_f_in;
         mag_f_ff     <= mag_f_in;
      end
      k_ff        <= k_in;
      mstep_ff    <= mstep_in;
      type_ff     <= type_in;
      v_ff        <= v_in;
      s_ff        <= s_in;
      product_ff  <= product_in;
      sq_a_ff     <= sq_a_in;
      sq_n_ff     <= sq_n_in;
      sq_r_ff     <= sq_r_in;
      sq_b_ff     <= sq_b_in;
      sq_cnt_ff   <= sq_cnt_in;
      pitch_ff    <= pitch_in;
      roll_ff     <= roll_in;
      head_ff     <= head_in;
      zwrap_ff    <= zwrap_in;
      cr_ff       <= cr_in;
      sr_ff       <= sr_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      srsp_ff     <= srsp_in;
      crsp_ff     <= crsp_in;
      mxi_ff      <= mxi_in;
      myi_ff      <= myi_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: design/tcc_cordic.sv
// ----------------------------------------------------------------------------
// tcc_cordic
// iterative cordic, vectoring (atan2) or rotation (sin/cos), one step a cycle
// ----------------------------------------------------------------------------
module tcc_cordic import tcc_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cord_ctl_type          cord_ctl,
   input  logic signed [XyW-1:0] x_start,
   input  logic signed [XyW-1:0] y_start,
   input  logic signed [ZW-1:0]  z_start,
   output logic                  done,
   output logic signed [XyW-1:0] x_res,
   output logic signed [XyW-1:0] y_res,
   output logic signed [ZW-1:0]  z_res
);

   localparam int IterW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERATIONS - 1);

   logic signed [XyW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic [IterW-1:0]      iter_ff, iter_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic                  zero_ff, zero_in, neg_ff, neg_in, rot_ff, rot_in;

   logic signed [XyW-1:0] dx, dy;
   logic signed [ZW-1:0]  ang;
   logic                  dir_pos;

   always_comb begin
      dx      = x_ff >>> iter_ff;
      dy      = y_ff >>> iter_ff;
      ang     = atan_step(5'(iter_ff));
      dir_pos = rot_ff ? (z_ff >= 0) : !(y_ff > 0);

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      neg_in  = neg_ff;
      rot_in  = rot_ff;

      if (cord_ctl.start) begin
         busy_in = 1'b1;
         iter_in = '0;
         rot_in  = cord_ctl.rotate;
         if (cord_ctl.rotate) begin
            x_in    = K_Q30;
            y_in    = '0;
            zero_in = 1'b0;
            // fold into the right half plane, negate at the end
            priority if (z_start > HALF_PI_Q28) begin
               z_in   = z_start - PI_Q28;
               neg_in = 1'b1;
            end else if (z_start < -HALF_PI_Q28) begin
               z_in   = z_start + PI_Q28;
               neg_in = 1'b1;
            end else begin
               z_in   = z_start;
               neg_in = 1'b0;
            end
         end else begin
            neg_in  = 1'b0;
            zero_in = (x_start == 0) && (y_start == 0);
            if (x_start < 0) begin
               x_in = -x_start;
               y_in = -y_start;
               z_in = (y_start >= 0) ? PI_Q28 : -PI_Q28;
            end else begin
               x_in = x_start;
               y_in = y_start;
               z_in = '0;
            end
         end
      end else if (busy_ff) begin
         if (dir_pos) begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + ang;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IterLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      zero_ff <= zero_in;
      neg_ff  <= neg_in;
      rot_ff  <= rot_in;
   end

   assign done  = done_ff;
   assign x_res = neg_ff ? -x_ff : x_ff;
   assign y_res = neg_ff ? -y_ff : y_ff;
   assign z_res = zero_ff ? '0 : z_ff;

endmodule
